### hdl/oal_pkg.sv
// shared types and constants for the ordered array list engine
// command codes, status codes and the controller/datapath interface structs
// no dependencies
`default_nettype none

package oal_pkg;

  // default number of list cells
  localparam int CapacityDef = 32;

  // field widths fixed by the command and result formats
  localparam int ActionW   = 3;
  localparam int PositionW = 5;
  localparam int ValueW    = 32;
  localparam int StatusW   = 2;
  localparam int IndexW    = 5;
  localparam int CountW    = 6;

  // command codes
  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_GET    = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new command
    logic rd;      // issue a store read
    logic use_rd;  // consume the read data (shift, compare or capture)
    logic put;     // write the new value at its position
    logic finish;  // commit count and results
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    action_e op;     // latched command code
    logic    op_ok;  // command code is a known one
    logic    err;    // command is refused
    logic    more;   // loop over entries has further work
    logic    match;  // read entry equals the search value
  } stat_t;

endpackage : oal_pkg

`default_nettype wire

### hdl/oal_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module oal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : oal_ram

`default_nettype wire

### hdl/oal_datapath.sv
// datapath of the ordered array list engine: command latch, entry store,
// loop counter, fill count and result registers; uses oal_pkg and oal_ram
`default_nettype none

module oal_datapath
  import oal_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [ActionW-1:0]   action_i,
  input  wire logic [PositionW-1:0] position_i,
  input  wire logic [ValueW-1:0]    value_i,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  output logic      [StatusW-1:0]   status_o,
  output logic      [ValueW-1:0]    data_o,
  output logic      [IndexW-1:0]    index_o,
  output logic      [CountW-1:0]    count_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = CW + PositionW;

  action_e          op_q;
  logic [PW-1:0]    pos_q;
  logic [ValueW-1:0] val_q;
  logic [CW-1:0]    k_q;
  logic [CW-1:0]    fill_q;
  logic             found_q;
  logic [ValueW-1:0] getd_q;

  logic [StatusW-1:0] status_q;
  logic [ValueW-1:0]  data_q;
  logic [IndexW-1:0]  index_q;
  logic [CountW-1:0]  count_q;

  logic [PW-1:0]     pos_in;
  logic [PW-1:0]     fill_w;
  logic [PW-1:0]     k_w;
  logic              full;
  status_e           err_code;
  logic              op_ok;
  logic              more;
  logic              match;
  logic [CW-1:0]     raddr_c;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [ValueW-1:0] ram_rdata;
  logic [CW-1:0]     fill_d;
  logic [PW-1:0]     index_wide;
  logic [PW:0]       count_wide;

  // widened views for compares
  assign pos_in = {{CW{1'b0}}, position_i};
  assign fill_w = {{PositionW{1'b0}}, fill_q};
  assign k_w    = {{PositionW{1'b0}}, k_q};
  assign full   = (fill_q == CW'(CAPACITY));
  assign match  = (ram_rdata == val_q);

  // refusal checks on the latched command
  always_comb begin
    err_code = ST_OK;
    op_ok    = 1'b1;
    case (op_q)
      ACT_INSERT: begin
        if (full) begin
          err_code = ST_FULL;
        end else if (pos_q > fill_w) begin
          err_code = ST_RANGE;
        end
      end
      ACT_APPEND: begin
        if (full) begin
          err_code = ST_FULL;
        end
      end
      ACT_DELETE, ACT_GET: begin
        if (pos_q >= fill_w) begin
          err_code = ST_RANGE;
        end
      end
      ACT_SEARCH: begin
        err_code = ST_OK;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // loop continuation and read address per command
  always_comb begin
    more    = 1'b0;
    raddr_c = k_q;
    case (op_q)
      ACT_INSERT, ACT_APPEND: begin
        more    = (k_w > pos_q);
        raddr_c = k_q - CW'(1);
      end
      ACT_DELETE: begin
        more    = ((k_w + PW'(1)) < fill_w);
        raddr_c = k_q + CW'(1);
      end
      ACT_SEARCH: begin
        more    = (k_w < fill_w);
        raddr_c = k_q;
      end
      ACT_GET: begin
        more    = 1'b0;
        raddr_c = pos_q[CW-1:0];
      end
      default: begin
        more    = 1'b0;
        raddr_c = k_q;
      end
    endcase
  end

  assign stat_o.op    = op_q;
  assign stat_o.op_ok = op_ok;
  assign stat_o.err   = (err_code != ST_OK);
  assign stat_o.more  = more;
  assign stat_o.match = match;

  // store writes: shifted entries during the loop, the new value at the end
  assign ram_we = cmd_i.put ||
                  (cmd_i.use_rd && (op_q inside {ACT_INSERT, ACT_APPEND, ACT_DELETE}));
  assign ram_waddr = cmd_i.put ? pos_q[AW-1:0] : k_q[AW-1:0];
  assign ram_wdata = cmd_i.put ? val_q : ram_rdata;

  oal_ram #(
    .WIDTH (ValueW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr_c[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // command latch, append goes in as an insert at the current count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= action_e'(action_i);
      val_q <= value_i;
      if (action_e'(action_i) == ACT_APPEND) begin
        pos_q <= fill_w;
      end else begin
        pos_q <= pos_in;
      end
    end
  end

  // loop counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (action_e'(action_i))
        ACT_INSERT, ACT_APPEND: k_q <= fill_q;
        ACT_DELETE:             k_q <= pos_in[CW-1:0];
        default:                k_q <= '0;
      endcase
    end else if (cmd_i.use_rd) begin
      case (op_q)
        ACT_INSERT, ACT_APPEND: k_q <= k_q - CW'(1);
        ACT_DELETE:             k_q <= k_q + CW'(1);
        ACT_SEARCH: begin
          if (!match) begin
            k_q <= k_q + CW'(1);
          end
        end
        default: k_q <= k_q;
      endcase
    end
  end

  // search hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.use_rd && op_q == ACT_SEARCH && match) begin
      found_q <= 1'b1;
    end
  end

  // get data capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.use_rd && op_q == ACT_GET) begin
      getd_q <= ram_rdata;
    end
  end

  // next fill count
  always_comb begin
    fill_d = fill_q;
    if (err_code == ST_OK) begin
      case (op_q)
        ACT_INSERT, ACT_APPEND: fill_d = fill_q + CW'(1);
        ACT_DELETE:             fill_d = fill_q - CW'(1);
        default:                fill_d = fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.finish) begin
      fill_q <= fill_d;
    end
  end

  assign index_wide = found_q ? k_w : '0;
  assign count_wide = {{(PositionW + 1){1'b0}}, fill_d};

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      count_q <= count_wide[CountW-1:0];
      index_q <= index_wide[IndexW-1:0];
      data_q  <= (op_q == ACT_GET && err_code == ST_OK) ? getd_q : '0;
      if (err_code != ST_OK) begin
        status_q <= err_code;
      end else if (op_q == ACT_SEARCH && !found_q) begin
        status_q <= ST_MISSING;
      end else begin
        status_q <= ST_OK;
      end
    end
  end

  assign status_o = status_q;
  assign data_o   = data_q;
  assign index_o  = index_q;
  assign count_o  = count_q;

  // the list never outgrows the store
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // the count moves only when a command is committed
  a_fill_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(fill_q))
    else $error("fill count changed outside commit");

  // a refused command never writes the store
  a_no_write_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (err_code == ST_OK && op_ok))
    else $error("store written by a refused command");

endmodule : oal_datapath

`default_nettype wire

### hdl/oal_ctrl.sv
// controller of the ordered array list engine: sequences checks, reads,
// shifts and the commit of one command; uses oal_pkg
`default_nettype none

module oal_ctrl
  import oal_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output logic       busy,
  output logic       done_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_READ   = 6'b000100,
    S_USE    = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.err || !stat_i.op_ok) begin
          state_d = S_FINISH;
        end else begin
          case (stat_i.op)
            ACT_INSERT, ACT_APPEND: state_d = stat_i.more ? S_READ : S_PUT;
            ACT_DELETE, ACT_SEARCH: state_d = stat_i.more ? S_READ : S_FINISH;
            ACT_GET:                state_d = S_READ;
            default:                state_d = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        state_d = S_USE;
      end
      S_USE: begin
        if (stat_i.op == ACT_GET || (stat_i.op == ACT_SEARCH && stat_i.match)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_PUT: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FINISH);
    end
  end

  // datapath commands
  assign cmd_o.load   = (state_q == S_IDLE) && start;
  assign cmd_o.rd     = (state_q == S_READ);
  assign cmd_o.use_rd = (state_q == S_USE);
  assign cmd_o.put    = (state_q == S_PUT);
  assign cmd_o.finish = (state_q == S_FINISH);

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // each command gives exactly one result strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a store read is always consumed in the next cycle
  a_read_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.use_rd)
    else $error("read data not consumed");

endmodule : oal_ctrl

`default_nettype wire

### hdl/ordered_array_list_engine.sv
// top level of the ordered array list engine
// joins oal_ctrl and oal_datapath; uses oal_pkg
//
// usage
// - a command (action_i, position_i, value_i) is taken at a rising edge with
//   start high and busy low; busy stays high until the command is committed
// - actions: insert at position, append, delete at position, search value,
//   get position; refused commands leave the list unchanged
// - the result (status_o, data_o, index_o, count_o) is shown for one cycle
//   with done_o high; the receiver cannot stall, and done_o comes in the cycle
//   in which busy has dropped, so the next command may be issued then
// - each command runs check, then read and use for each moved or compared
//   entry, put for insert and append, and finish; a search stops at its first
//   hit, a get reads its one entry, and refused or unknown commands go from
//   check straight to finish
// - the entries sit in one ram with one write and one registered read port;
//   every moved or compared entry passes through a check, read and use state
// - reset clears the fill count and the controller; the store keeps its
//   contents undefined, entries are only read after they were written
`default_nettype none

module ordered_array_list_engine
  import oal_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ActionW-1:0]   action_i,
  input  wire logic [PositionW-1:0] position_i,
  input  wire logic [ValueW-1:0]    value_i,
  output logic                      done_o,
  output logic      [StatusW-1:0]   status_o,
  output logic      [ValueW-1:0]    data_o,
  output logic      [IndexW-1:0]    index_o,
  output logic      [CountW-1:0]    count_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  oal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // store and result logic
  oal_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (status_o),
    .data_o     (data_o),
    .index_o    (index_o),
    .count_o    (count_o)
  );

endmodule : ordered_array_list_engine

`default_nettype wire

### test/ordered_array_list_engine_test.sv
`timescale 1ns / 100ps
// self-checking testbench for ordered_array_list_engine: directed and random commands
// with a shadow list predictor; depends on oal_pkg and the engine rtl under hdl/

module ordered_array_list_engine_test;
  import oal_pkg::*;

  localparam int Capacity    = CapacityDef;
  localparam int IdlePct     = 14;
  localparam int StallLimit  = 4000;
  localparam int DrainCycles = 120;
  localparam int RandomItems = 520;

  // action codes that the engine treats as no operation
  localparam logic [ActionW-1:0] ActUnusedFirst = 3'd5;
  localparam logic [ActionW-1:0] ActUnusedMid   = 3'd6;
  localparam logic [ActionW-1:0] ActUnusedLast  = 3'd7;

  localparam logic [ValueW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValueW-1:0] ValMax = 32'h7fff_ffff;

  typedef struct {
    status_e              status;
    logic [ValueW-1:0]    data;
    logic [IndexW-1:0]    index;
    logic [CountW-1:0]    count;
  } list_result_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start      = 1'b0;
  logic                 busy;
  logic [ActionW-1:0]   action_i   = '0;
  logic [PositionW-1:0] position_i = '0;
  logic [ValueW-1:0]    value_i    = '0;
  logic                 done_o;
  logic [StatusW-1:0]   status_o;
  logic [ValueW-1:0]    data_o;
  logic [IndexW-1:0]    index_o;
  logic [CountW-1:0]    count_o;

  // list contents and length the engine should hold
  logic [ValueW-1:0] shadow_list [Capacity];
  int unsigned       shadow_len = 0;
  list_result_t      expected_results [$];
  int                errors       = 0;
  int                idle_pct     = IdlePct;
  int                stall_cycles = 0;

  ordered_array_list_engine #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .action_i  (action_i),
    .position_i(position_i),
    .value_i   (value_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .data_o    (data_o),
    .index_o   (index_o),
    .count_o   (count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // update the shadow list for one accepted command and queue its result
  function automatic void apply_list_cmd(logic [ActionW-1:0] act, logic [PositionW-1:0] pos,
                                         logic [ValueW-1:0] val);
    list_result_t r;
    int unsigned  k;
    r.status = ST_OK;
    r.data   = '0;
    r.index  = '0;
    case (act)
      ACT_INSERT: begin
        if (shadow_len >= Capacity) begin
          r.status = ST_FULL;
        end else if (pos > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = shadow_len; k > pos; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      ACT_APPEND: begin
        if (shadow_len >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      ACT_DELETE: begin
        if (pos >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = pos; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
          shadow_len--;
        end
      end
      ACT_SEARCH: begin
        r.status = ST_MISSING;
        for (k = 0; k < shadow_len; k++) begin
          if (shadow_list[k] == val) begin
            r.status = ST_OK;
            r.index  = k[IndexW-1:0];
            break;
          end
        end
      end
      ACT_GET: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else r.data = shadow_list[pos];
      end
      default: ;
    endcase
    r.count = shadow_len[CountW-1:0];
    expected_results.push_back(r);
  endfunction

  // extremes, small values that repeat, and plain random words
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0: return ValMin;
      1: return ValMax;
      2: return '0;
      3: return '1;
      4, 5: return ValueW'($urandom_range(7));
      default: return ValueW'($urandom);
    endcase
  endfunction

  // mostly a position up to hi, now and then any position
  function automatic logic [PositionW-1:0] pick_pos(int unsigned hi);
    if (hi > 31) hi = 31;
    if ($urandom_range(99) < 85) return PositionW'($urandom_range(hi));
    return PositionW'($urandom_range(31));
  endfunction

  // one command transfer, with a random hold-off before start rises
  task automatic send_cmd(logic [ActionW-1:0] act, logic [PositionW-1:0] pos,
                          logic [ValueW-1:0] val);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
    apply_list_cmd(act, pos, val);
  endtask

  // refusals and no-ops on an empty list
  task automatic test_empty_list();
    send_cmd(ACT_GET, '0, '0);
    send_cmd(ACT_DELETE, '0, '0);
    send_cmd(ACT_SEARCH, '0, '0);
    send_cmd(ACT_INSERT, 5'd1, 32'd5);
    send_cmd(ActUnusedFirst, '1, ValMin);
    send_cmd(ActUnusedMid, 5'd10, '1);
    send_cmd(ActUnusedLast, 5'd21, ValMax);
    send_cmd(ACT_GET, '1, '0);
  endtask

  // extreme values, insert at the end, first match on duplicates, end deletes
  task automatic test_edge_values();
    send_cmd(ACT_INSERT, '0, ValMin);
    send_cmd(ACT_APPEND, '1, ValMax);
    send_cmd(ACT_INSERT, 5'd2, '1);
    send_cmd(ACT_INSERT, 5'd1, '0);
    send_cmd(ACT_INSERT, 5'd5, 32'd9);
    send_cmd(ACT_GET, 5'd3, '0);
    send_cmd(ACT_GET, 5'd4, '0);
    send_cmd(ACT_GET, '0, '0);
    send_cmd(ACT_APPEND, '0, '0);
    send_cmd(ACT_SEARCH, '0, '0);
    send_cmd(ACT_SEARCH, '0, 32'd12345);
    send_cmd(ACT_SEARCH, '0, ValMax);
    send_cmd(ACT_DELETE, 5'd4, '0);
    send_cmd(ACT_DELETE, '0, '0);
    send_cmd(ACT_DELETE, '1, '0);
    send_cmd(ACT_INSERT, 5'd21, 32'd1);
    send_cmd(ACT_GET, 5'd10, '0);
  endtask

  // fill to capacity, hit the full refusals, then drain to empty
  task automatic test_fill_and_drain();
    while (shadow_len < Capacity) begin
      if ($urandom_range(1)) send_cmd(ACT_APPEND, PositionW'($urandom), pick_value());
      else send_cmd(ACT_INSERT, pick_pos(shadow_len), pick_value());
    end
    send_cmd(ACT_APPEND, '0, pick_value());
    send_cmd(ACT_INSERT, '0, pick_value());
    send_cmd(ACT_INSERT, '1, pick_value());
    send_cmd(ACT_GET, '1, '0);
    send_cmd(ACT_SEARCH, '0, shadow_list[Capacity-1]);
    while (shadow_len > 0) send_cmd(ACT_DELETE, pick_pos(shadow_len - 1), pick_value());
  endtask

  // random mix steered toward a moving target length
  task automatic test_random_mix(int n);
    int                   target;
    int                   r;
    logic [ActionW-1:0]   act;
    logic [PositionW-1:0] pos;
    logic [ValueW-1:0]    val;
    target = 0;
    for (int i = 0; i < n; i++) begin
      // one long stretch with no hold-off
      idle_pct = (i >= n / 3 && i < n / 3 + 150) ? 0 : IdlePct;
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0: target = 0;
          1: target = Capacity;
          default: target = $urandom_range(Capacity);
        endcase
      end
      r   = $urandom_range(99);
      val = pick_value();
      pos = pick_pos(shadow_len > 0 ? shadow_len - 1 : 0);
      if (r < 4) begin
        act = ActionW'(ActUnusedFirst + $urandom_range(2));
        pos = PositionW'($urandom);
      end else if (r < 22) begin
        act = ACT_SEARCH;
        if (shadow_len > 0 && $urandom_range(9) < 7)
          val = shadow_list[$urandom_range(shadow_len - 1)];
      end else if (r < 38) begin
        act = ACT_GET;
      end else if (shadow_len < target || (shadow_len == target && $urandom_range(2) == 0)) begin
        if ($urandom_range(9) < 6) begin
          act = ACT_INSERT;
          pos = pick_pos(shadow_len);
        end else begin
          act = ACT_APPEND;
        end
      end else begin
        act = ACT_DELETE;
      end
      send_cmd(act, pos, val);
    end
    idle_pct = IdlePct;
  endtask

  // compare each result with the oldest queued expectation
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && done_o !== 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding: status %0d count %0d", status_o, count_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          errors++;
        end
        if (data_o !== exp_r.data) begin
          $error("data: expected %h, got %h", exp_r.data, data_o);
          errors++;
        end
        if (index_o !== exp_r.index) begin
          $error("index: expected %0d, got %0d", exp_r.index, index_o);
          errors++;
        end
        if (count_o !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, count_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no command transfer and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edge_values();
    test_fill_and_drain();
    test_random_mix(RandomItems);
    start <= 1'b0;
    // let outstanding results arrive, then watch for strays
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hdl/oal_pkg.sv
hdl/oal_ram.sv
hdl/oal_datapath.sv
hdl/oal_ctrl.sv
hdl/ordered_array_list_engine.sv
test/ordered_array_list_engine_test.sv
